// ===== hdl/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types, constants and bit functions for the adjacency matrix engine.
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int ROW_MAX          = 64;
    localparam int VC_W             = 7;
    localparam int V_W              = 6;
    localparam int TALLY_W          = 13;
    localparam int POP_W            = 7;

    typedef enum logic [2:0] {
        K_ADD    = 3'd0,
        K_REMOVE = 3'd1,
        K_CHECK  = 3'd2,
        K_DEGREE = 3'd3,
        K_NEIGH  = 3'd4,
        K_COUNT  = 3'd5,
        K_CLEAR  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_SCAN,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic                done;
        logic [TALLY_W-1:0]  total;
    } t_sum_stat;

    // adder tree, one level per loop
    function automatic logic [POP_W-1:0] f_popcount(logic [ROW_MAX-1:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++) s1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
        for (int i = 0; i < 16; i++) s2[i] = 3'(s1[2*i]) + 3'(s1[2*i+1]);
        for (int i = 0; i < 8; i++)  s3[i] = 4'(s2[2*i]) + 4'(s2[2*i+1]);
        for (int i = 0; i < 4; i++)  s4[i] = 5'(s3[2*i]) + 5'(s3[2*i+1]);
        for (int i = 0; i < 2; i++)  s5[i] = 6'(s4[2*i]) + 6'(s4[2*i+1]);
        return POP_W'(s5[0]) + POP_W'(s5[1]);
    endfunction

    // isolate the lowest set bit, then encode it
    function automatic logic [V_W-1:0] f_low_index(logic [ROW_MAX-1:0] v);
        logic [ROW_MAX-1:0] low;
        logic [V_W-1:0]     idx;
        low = v & (~v + ROW_MAX'(1));
        idx = '0;
        for (int k = 0; k < ROW_MAX; k++) begin
            if (low[k]) begin
                idx = idx | V_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/ame_ram.sv =====
// ----------------------------------------------------------------------------
// ame_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ame_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ame_sum.sv =====
// ----------------------------------------------------------------------------
// ame_sum
// Edge count walker: reads the live rows one per cycle, popcounts each row in
// a register stage and accumulates the total.
// ----------------------------------------------------------------------------
module ame_sum #(
    parameter int  MAX_VERTICES = ame_pkg::MAX_VERTICES_DEF,
    localparam int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_ack,
    input  logic [ame_pkg::VC_W-1:0]  i_live,
    input  logic [MAX_VERTICES-1:0]   i_row,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    output ame_pkg::t_sum_stat        o_stat
);

    logic [ame_pkg::VC_W-1:0]    r_ptr;
    logic                        r_run;
    logic                        r_pend;
    logic                        r_pop_vld;
    logic [ame_pkg::POP_W-1:0]   r_pop;
    logic [ame_pkg::TALLY_W-1:0] r_total;
    logic                        r_done;
    logic                        rd_en;
    logic                        finish;

    assign rd_en  = r_run && (r_ptr < i_live);
    // all rows issued and the pipeline has drained
    assign finish = r_run && !rd_en && !r_pend && !r_pop_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_run     <= 1'b0;
            r_pend    <= 1'b0;
            r_pop_vld <= 1'b0;
            r_total   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_pend    <= rd_en;
            r_pop_vld <= r_pend;
            if (i_start) begin
                r_ptr   <= '0;
                r_run   <= 1'b1;
                r_total <= '0;
                r_done  <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_ptr <= r_ptr + ame_pkg::VC_W'(1);
                end
                if (r_pop_vld) begin
                    r_total <= r_total + ame_pkg::TALLY_W'(r_pop);
                end
                if (finish) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else if (i_ack) begin
                    r_done <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop <= ame_pkg::f_popcount(ame_pkg::ROW_MAX'(i_row));
    end

    assign o_rd_en      = rd_en;
    assign o_rd_addr    = r_ptr[AW-1:0];
    assign o_stat.done  = r_done;
    assign o_stat.total = r_total;

endmodule

// ===== hdl/adjacency_matrix_engine.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_engine
// Directed graph kept as a bit matrix in a row RAM, with edge operations,
// degree, neighbour listing, edge count and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time. Add, remove, check, degree, clear and the
// unused kind read the row from the row RAM in the accept cycle; the row is
// modified, written back and answered in the row state once the output
// register is free. Neighbour listing reads the row the same way and then
// gives each listed neighbour as one transfer. Edge count walks the live
// rows through the single RAM read port, one row a cycle, and answers with
// the total once the walk has drained. A result sits in an output register,
// so it can wait on a stalled consumer. Each row has a valid flag that reset
// and clear drop at once, so there is no clearing pass after reset.
module adjacency_matrix_engine #(
    parameter int MAX_VERTICES = ame_pkg::MAX_VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ame_pkg::VC_W-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_kind,
    input  logic [ame_pkg::V_W-1:0]      i_from_vertex,
    input  logic [ame_pkg::V_W-1:0]      i_to_vertex,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_edge_present,
    output logic [ame_pkg::TALLY_W-1:0]  o_tally,
    output logic [ame_pkg::V_W-1:0]      o_neighbour_index,
    output logic                         o_found,
    output logic                         o_last
);

    localparam int W  = MAX_VERTICES;
    localparam int AW = $clog2(MAX_VERTICES);

    ame_pkg::t_state r_state, n_state;
    ame_pkg::t_kind  r_kind, in_kind;

    logic [ame_pkg::VC_W-1:0]    r_vertex_count;
    logic [ame_pkg::VC_W-1:0]    live;
    logic [W-1:0]                cols;
    logic [W-1:0]                r_row_vld;
    logic                        r_rd_ok;
    logic [ame_pkg::V_W-1:0]     r_a, r_b;
    logic                        r_a_ok, r_both;
    logic [W-1:0]                r_bits;
    logic [W-1:0]                rest;

    logic [W-1:0]                rdata, row_raw, row_m;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        ram_we;
    logic [W-1:0]                ram_wdata;
    logic                        in_xfer, out_free;

    logic                        row_rd, sum_start, sum_ack, clear_all;
    logic                        bits_load, bits_step;
    logic                        sum_rd_en;
    logic [AW-1:0]               sum_rd_addr;
    ame_pkg::t_sum_stat          sum_stat;

    logic                        emit;
    logic                        n_edge_present, n_found, n_last;
    logic [ame_pkg::TALLY_W-1:0] n_tally;
    logic [ame_pkg::V_W-1:0]     n_nidx;

    logic                        r_out_valid;
    logic                        r_edge_present, r_found, r_last;
    logic [ame_pkg::TALLY_W-1:0] r_tally;
    logic [ame_pkg::V_W-1:0]     r_nidx;

    assign in_kind  = ame_pkg::t_kind'(i_kind);
    assign in_xfer  = i_in_valid && (r_state == ame_pkg::ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign live = (r_vertex_count > ame_pkg::VC_W'(MAX_VERTICES)) ?
                  ame_pkg::VC_W'(MAX_VERTICES) : r_vertex_count;

    always_comb begin
        for (int j = 0; j < W; j++) begin
            cols[j] = ame_pkg::VC_W'(j) < live;
        end
    end

    // a row never written since reset or clear reads as empty
    assign row_raw = r_rd_ok ? rdata : '0;
    assign row_m   = row_raw & cols & {W{r_a_ok}};
    assign rest    = r_bits & (r_bits - W'(1));

    assign rd_en   = row_rd || sum_rd_en;
    assign rd_addr = row_rd ? i_from_vertex[AW-1:0] : sum_rd_addr;

    ame_ram #(
        .WIDTH (W),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    ame_sum #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sum_start),
        .i_ack     (sum_ack),
        .i_live    (live),
        .i_row     (row_raw & cols),
        .o_rd_en   (sum_rd_en),
        .o_rd_addr (sum_rd_addr),
        .o_stat    (sum_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ame_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (in_kind == ame_pkg::K_COUNT) ?
                              ame_pkg::ST_SUM : ame_pkg::ST_ROW;
                end
            end
            ame_pkg::ST_ROW: begin
                if (r_kind == ame_pkg::K_NEIGH && row_m != '0) begin
                    n_state = ame_pkg::ST_SCAN;
                end else if (out_free) begin
                    n_state = ame_pkg::ST_IDLE;
                end
            end
            ame_pkg::ST_SCAN: begin
                if (out_free && rest == '0) begin
                    n_state = ame_pkg::ST_IDLE;
                end
            end
            ame_pkg::ST_SUM: begin
                if (out_free && sum_stat.done) begin
                    n_state = ame_pkg::ST_IDLE;
                end
            end
            default: n_state = ame_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        row_rd         = 1'b0;
        sum_start      = 1'b0;
        sum_ack        = 1'b0;
        clear_all      = 1'b0;
        bits_load      = 1'b0;
        bits_step      = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = row_raw;
        emit           = 1'b0;
        n_edge_present = 1'b0;
        n_tally        = '0;
        n_nidx         = '0;
        n_found        = 1'b0;
        n_last         = 1'b1;
        unique case (r_state)
            ame_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (in_kind == ame_pkg::K_COUNT) begin
                        sum_start = 1'b1;
                    end else begin
                        row_rd = 1'b1;
                    end
                end
            end
            ame_pkg::ST_ROW: begin
                if (r_kind == ame_pkg::K_NEIGH && row_m != '0) begin
                    bits_load = 1'b1;
                end else if (out_free) begin
                    emit = 1'b1;
                    unique case (r_kind)
                        ame_pkg::K_ADD: begin
                            ram_we    = r_both;
                            ram_wdata = row_raw | (W'(1) << r_b[AW-1:0]);
                        end
                        ame_pkg::K_REMOVE: begin
                            ram_we    = r_both;
                            ram_wdata = row_raw & ~(W'(1) << r_b[AW-1:0]);
                        end
                        ame_pkg::K_CHECK: begin
                            n_edge_present = r_both && row_raw[r_b[AW-1:0]];
                        end
                        ame_pkg::K_DEGREE: begin
                            n_tally = ame_pkg::TALLY_W'(
                                ame_pkg::f_popcount(ame_pkg::ROW_MAX'(row_m)));
                        end
                        ame_pkg::K_CLEAR: begin
                            clear_all = 1'b1;
                        end
                        default: begin
                            // plain acknowledge, also an empty neighbour list
                        end
                    endcase
                end
            end
            ame_pkg::ST_SCAN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    bits_step = 1'b1;
                    n_found   = 1'b1;
                    n_nidx    = ame_pkg::f_low_index(ame_pkg::ROW_MAX'(r_bits));
                    n_last    = (rest == '0);
                end
            end
            ame_pkg::ST_SUM: begin
                if (out_free && sum_stat.done) begin
                    emit    = 1'b1;
                    sum_ack = 1'b1;
                    n_tally = sum_stat.total;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ame_pkg::ST_IDLE;
            r_vertex_count <= '0;
            r_row_vld      <= '0;
            r_rd_ok        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            if (clear_all) begin
                r_row_vld <= '0;
            end else if (ram_we) begin
                r_row_vld[r_a[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_row_vld[rd_addr];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= in_kind;
            r_a    <= i_from_vertex;
            r_b    <= i_to_vertex;
            r_a_ok <= {1'b0, i_from_vertex} < live;
            r_both <= ({1'b0, i_from_vertex} < live) && ({1'b0, i_to_vertex} < live);
        end
        if (bits_load) begin
            r_bits <= row_m;
        end else if (bits_step) begin
            r_bits <= rest;
        end
        if (emit) begin
            r_edge_present <= n_edge_present;
            r_tally        <= n_tally;
            r_nidx         <= n_nidx;
            r_found        <= n_found;
            r_last         <= n_last;
        end
    end

    assign o_in_stall        = (r_state != ame_pkg::ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_edge_present    = r_edge_present;
    assign o_tally           = r_tally;
    assign o_neighbour_index = r_nidx;
    assign o_found           = r_found;
    assign o_last            = r_last;

endmodule

// ===== hdl/ame_checker.sv =====
// ----------------------------------------------------------------------------
// ame_checker
// Port level checks on the result channel of the adjacency matrix engine.
// ----------------------------------------------------------------------------
module ame_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_stall,
    input logic                         o_out_valid,
    input logic                         o_edge_present,
    input logic [ame_pkg::TALLY_W-1:0]  o_tally,
    input logic [ame_pkg::V_W-1:0]      o_neighbour_index,
    input logic                         o_found,
    input logic                         o_last
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // only a neighbour listing gives more than one result
    a_multi_is_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_found)
        else $error("non-final result that is not a neighbour");

    // a listed neighbour carries no other answer
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> (o_tally == '0) && !o_edge_present)
        else $error("neighbour result with tally or edge bit");

    a_no_index_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_neighbour_index == '0))
        else $error("neighbour index without a neighbour");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tally)
            && $stable(o_neighbour_index) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind adjacency_matrix_engine ame_checker u_ame_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_stall       (i_out_stall),
    .o_out_valid       (o_out_valid),
    .o_edge_present    (o_edge_present),
    .o_tally           (o_tally),
    .o_neighbour_index (o_neighbour_index),
    .o_found           (o_found),
    .o_last            (o_last)
);

// ===== dv/adjacency_matrix_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adjacency_matrix_engine_tb
// Drives edge, degree, neighbour, count and clear requests into the graph
// engine under bursty input and a stalling consumer. Every answer is
// compared field by field with a local copy of the bit matrix.
// ----------------------------------------------------------------------------
module adjacency_matrix_engine_tb;

    localparam int         TALLY_W       = ame_pkg::TALLY_W;
    localparam int         V_W           = ame_pkg::V_W;
    localparam int         VC_W          = ame_pkg::VC_W;
    localparam logic [2:0] K_UNUSED      = 3'd7;
    localparam int         HALF_PERIOD   = 6;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_ITEMS   = 28;
    localparam int         PHASES        = 9;

    typedef struct packed {
        logic                present;
        logic [TALLY_W-1:0]  tally;
        logic [V_W-1:0]      nidx;
        logic                found;
        logic                last;
    } t_result;

    typedef struct packed {
        bit                  is_cfg;
        logic [VC_W-1:0]     cfg_value;
        logic [2:0]          kind;
        logic [V_W-1:0]      from_v;
        logic [V_W-1:0]      to_v;
        bit                  typed;
        t_result             want;
    } t_step;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [VC_W-1:0]     i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [2:0]          i_kind;
    logic [V_W-1:0]      i_from_vertex;
    logic [V_W-1:0]      i_to_vertex;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_edge_present;
    logic [TALLY_W-1:0]  o_tally;
    logic [V_W-1:0]      o_neighbour_index;
    logic                o_found;
    logic                o_last;

    // local copy of the matrix and the live vertex count
    logic [63:0]         graph_rows [64];
    int                  live_n;
    t_result             pending_results [$];

    int                  mismatches;
    int                  requests_sent;
    int                  kind_hits [8];
    int                  answers_seen;
    int                  neighbours_seen;
    int                  settings_used;
    int                  burst_left;
    int                  hold_seq;
    int                  hold_seen;
    int                  hold_left;
    int                  stall_mode;
    int                  mode_left;
    int                  quiet_cycles;
    int                  vc_plan [PHASES];
    t_step               plan [$];

    adjacency_matrix_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_from_vertex     (i_from_vertex),
        .i_to_vertex       (i_to_vertex),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_edge_present    (o_edge_present),
        .o_tally           (o_tally),
        .o_neighbour_index (o_neighbour_index),
        .o_found           (o_found),
        .o_last            (o_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic void queue_result(input t_result r);
        pending_results = {pending_results, r};
    endfunction

    function automatic void add_step(input t_step s);
        plan = {plan, s};
    endfunction

    // works out the answers of one request and updates the matrix copy
    function automatic void model_request(input logic [2:0] kind,
                                          input logic [V_W-1:0] a,
                                          input logic [V_W-1:0] b, input bit keep);
        logic [63:0]        cols;
        logic [63:0]        bits;
        logic [TALLY_W-1:0] total;
        bit                 a_live;
        bit                 both;
        t_result            r;
        cols   = (live_n >= 64) ? {64{1'b1}} : ((64'd1 << live_n) - 64'd1);
        a_live = (a < live_n);
        both   = a_live && (b < live_n);
        r      = '0;
        r.last = 1'b1;
        bits   = '0;
        total  = '0;
        case (kind)
            ame_pkg::K_ADD: begin
                if (both) graph_rows[a][b] = 1'b1;
            end
            ame_pkg::K_REMOVE: begin
                if (both) graph_rows[a][b] = 1'b0;
            end
            ame_pkg::K_CHECK: begin
                r.present = both ? graph_rows[a][b] : 1'b0;
            end
            ame_pkg::K_DEGREE: begin
                if (a_live) r.tally = TALLY_W'($countones(graph_rows[a] & cols));
            end
            ame_pkg::K_NEIGH: begin
                if (a_live) bits = graph_rows[a] & cols;
            end
            ame_pkg::K_COUNT: begin
                for (int i = 0; i < live_n; i++) begin
                    total += TALLY_W'($countones(graph_rows[i] & cols));
                end
                r.tally = total;
            end
            ame_pkg::K_CLEAR: begin
                for (int i = 0; i < 64; i++) graph_rows[i] = '0;
            end
            default: begin
            end
        endcase
        if (!keep) return;
        if (kind == ame_pkg::K_NEIGH && bits != 64'd0) begin
            for (int i = 0; i < 64; i++) begin
                if (bits[i]) begin
                    r.nidx  = V_W'(i);
                    r.found = 1'b1;
                    r.last  = ((bits >> (i + 1)) == 64'd0);
                    queue_result(r);
                end
            end
        end else begin
            queue_result(r);
        end
    endfunction

    function automatic t_result answer(input logic present, input int tally,
                                       input logic found);
        t_result r;
        r         = '0;
        r.present = present;
        r.tally   = TALLY_W'(tally);
        r.found   = found;
        r.last    = 1'b1;
        return r;
    endfunction

    function automatic t_step request_row(input logic [2:0] k, input int f, input int t);
        t_step s;
        s        = '0;
        s.kind   = k;
        s.from_v = V_W'(f);
        s.to_v   = V_W'(t);
        return s;
    endfunction

    function automatic t_step checked_row(input logic [2:0] k, input int f, input int t,
                                          input t_result w);
        t_step s;
        s       = request_row(k, f, t);
        s.typed = 1'b1;
        s.want  = w;
        return s;
    endfunction

    function automatic t_step config_row(input int v);
        t_step s;
        s           = '0;
        s.is_cfg    = 1'b1;
        s.cfg_value = VC_W'(v);
        return s;
    endfunction

    // mostly vertices in use, now and then any index
    function automatic logic [V_W-1:0] pick_vertex();
        if (live_n != 0 && $urandom_range(0, 7) != 0) begin
            return V_W'($urandom_range(0, live_n - 1));
        end
        return V_W'($urandom_range(0, 63));
    endfunction

    task automatic pick_request(output logic [2:0] k, output logic [V_W-1:0] f,
                                output logic [V_W-1:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)      k = ame_pkg::K_ADD;
        else if (r < 52) k = ame_pkg::K_REMOVE;
        else if (r < 67) k = ame_pkg::K_CHECK;
        else if (r < 77) k = ame_pkg::K_DEGREE;
        else if (r < 89) k = ame_pkg::K_NEIGH;
        else if (r < 95) k = ame_pkg::K_COUNT;
        else if (r < 97) k = ame_pkg::K_CLEAR;
        else             k = K_UNUSED;
        f = pick_vertex();
        t = pick_vertex();
    endtask

    task automatic send_request(input logic [2:0] k, input logic [V_W-1:0] f,
                                input logic [V_W-1:0] t, input bit paced,
                                input bit typed, input t_result want);
        int gap;
        if (paced) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_in_valid    <= 1'b1;
        i_kind        <= k;
        i_from_vertex <= f;
        i_to_vertex   <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_request(k, f, t, !typed);
        if (typed) queue_result(want);
        requests_sent++;
        kind_hits[k]++;
    endtask

    task automatic wait_all_answered();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [VC_W-1:0] v);
        wait_all_answered();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        live_n = (v > 64) ? 64 : int'(v);
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [TALLY_W-1:0] want,
                                 input logic [TALLY_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // consumer: random stall patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            answers_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: answer with no request waiting, expected none, got tally %0d",
                         $time, o_tally);
            end else begin
                want = pending_results.pop_front();
                compare_field("edge_present", TALLY_W'(want.present),
                              TALLY_W'(o_edge_present));
                compare_field("tally", want.tally, o_tally);
                compare_field("neighbour_index", TALLY_W'(want.nidx),
                              TALLY_W'(o_neighbour_index));
                compare_field("found", TALLY_W'(want.found), TALLY_W'(o_found));
                compare_field("last", TALLY_W'(want.last), TALLY_W'(o_last));
                if (o_found === 1'b1) neighbours_seen++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("adjacency_matrix_engine_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [2:0]     k;
        logic [V_W-1:0] f;
        logic [V_W-1:0] t;
        logic [V_W-1:0] v;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_kind        <= '0;
        i_from_vertex <= '0;
        i_to_vertex   <= '0;
        i_out_stall   <= 1'b0;
        mismatches = 0; requests_sent = 0; answers_seen = 0; neighbours_seen = 0;
        settings_used = 0; burst_left = 0; hold_seq = 0; hold_seen = 0; hold_left = 0;
        stall_mode = 0; mode_left = 0; quiet_cycles = 0; live_n = 0;
        for (int i = 0; i < 8; i++) kind_hits[i] = 0;
        for (int i = 0; i < 64; i++) graph_rows[i] = '0;
        vc_plan = '{64, 9, 2, 1, 127, 100, 33, 5, 64};

        // nothing is in use right after reset
        add_step(checked_row(ame_pkg::K_CHECK, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_DEGREE, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_NEIGH, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_COUNT, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_ADD, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(K_UNUSED, 63, 63, answer(0, 0, 0)));
        add_step(config_row(64));
        add_step(checked_row(ame_pkg::K_ADD, 63, 63, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_ADD, 63, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_ADD, 0, 63, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_CHECK, 63, 63, answer(1, 0, 0)));
        add_step(checked_row(ame_pkg::K_DEGREE, 63, 0, answer(0, 2, 0)));
        add_step(request_row(ame_pkg::K_NEIGH, 63, 0));
        add_step(checked_row(ame_pkg::K_COUNT, 0, 0, answer(0, 3, 0)));
        add_step(checked_row(ame_pkg::K_REMOVE, 63, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_CHECK, 63, 0, answer(0, 0, 0)));
        add_step(request_row(ame_pkg::K_NEIGH, 0, 0));
        add_step(checked_row(K_UNUSED, 0, 0, answer(0, 0, 0)));
        // count above the matrix size acts as full size
        add_step(config_row(127));
        add_step(checked_row(ame_pkg::K_ADD, 5, 62, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_COUNT, 0, 0, answer(0, 3, 0)));
        // shrink: stale bits stay but are not seen
        add_step(config_row(32));
        add_step(checked_row(ame_pkg::K_DEGREE, 63, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_DEGREE, 5, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_CHECK, 63, 63, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_REMOVE, 63, 63, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_NEIGH, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_COUNT, 0, 0, answer(0, 0, 0)));
        add_step(config_row(64));
        add_step(checked_row(ame_pkg::K_CHECK, 63, 63, answer(1, 0, 0)));
        add_step(checked_row(ame_pkg::K_CLEAR, 0, 0, answer(0, 0, 0)));
        add_step(checked_row(ame_pkg::K_COUNT, 0, 0, answer(0, 0, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_vertex_count(plan[i].cfg_value);
            end else begin
                send_request(plan[i].kind, plan[i].from_v, plan[i].to_v, 1'b1,
                             plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_vertex_count(VC_W'(vc_plan[p]));
            if (p == 0) begin
                // consumer holds off while requests keep coming back to back
                hold_seq <= hold_seq + 1;
                repeat (40) begin
                    pick_request(k, f, t);
                    send_request(k, f, t, 1'b0, 1'b0, '0);
                end
                // full row, then list all 64 neighbours
                v = V_W'($urandom_range(0, 63));
                for (int j = 0; j < 64; j++) begin
                    send_request(ame_pkg::K_ADD, v, V_W'(j), 1'b1, 1'b0, '0);
                end
                send_request(ame_pkg::K_NEIGH, v, '0, 1'b1, 1'b0, '0);
                send_request(ame_pkg::K_DEGREE, v, '0, 1'b1, 1'b0, '0);
            end
            repeat (PHASE_ITEMS) begin
                pick_request(k, f, t);
                send_request(k, f, t, 1'b1, 1'b0, '0);
            end
        end

        wait_all_answered();
        $display("covered %0d requests (%0d add, %0d remove, %0d check, %0d degree,",
                 requests_sent, kind_hits[ame_pkg::K_ADD], kind_hits[ame_pkg::K_REMOVE],
                 kind_hits[ame_pkg::K_CHECK], kind_hits[ame_pkg::K_DEGREE]);
        $display("  %0d list, %0d count, %0d clear, %0d unused), %0d answers,",
                 kind_hits[ame_pkg::K_NEIGH], kind_hits[ame_pkg::K_COUNT],
                 kind_hits[ame_pkg::K_CLEAR], kind_hits[K_UNUSED], answers_seen);
        $display("  %0d neighbours, %0d settings", neighbours_seen, settings_used);
        if (mismatches == 0) begin
            $display("adjacency_matrix_engine_tb: PASS");
        end else begin
            $display("adjacency_matrix_engine_tb: FAIL");
        end
        $finish;
    end

endmodule
